[rtl/tpsbb_pkg.sv]
// Package of the two-port serial byte bridge.
// Holds the operation codes, the controller states and the fixed field widths.
// No dependencies.
`default_nettype none

package tpsbb_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned IDX_W  = 5;

  typedef enum logic [1:0] {
    OP_RX_BYTE    = 2'd0,
    OP_TX_READY   = 2'd1,
    OP_LOAD_TEXT  = 2'd2,
    OP_START_TEXT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef logic [DATA_W-1:0] byte_t;

endpackage

`default_nettype wire

[rtl/tpsbb_if.sv]
// Channel interfaces of the two-port serial byte bridge: event input and result output.
// Each carries valid, ready and the payload. Depends on tpsbb_pkg.
`default_nettype none

interface tpsbb_in_if import tpsbb_pkg::*; ();
  logic             valid;
  logic             ready;
  op_e              operation;
  logic             port;
  byte_t            data_byte;
  logic [IDX_W-1:0] text_index;

  modport source (output valid, output operation, output port, output data_byte,
                  output text_index, input ready);
  modport sink   (input valid, input operation, input port, input data_byte,
                  input text_index, output ready);
endinterface

interface tpsbb_out_if import tpsbb_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  sent_valid;
  byte_t sent_byte;
  logic  queue_dropped;
  logic  tx_request_a;
  logic  tx_request_b;

  modport source (output valid, output sent_valid, output sent_byte, output queue_dropped,
                  output tx_request_a, output tx_request_b, input ready);
  modport sink   (input valid, input sent_valid, input sent_byte, input queue_dropped,
                  input tx_request_a, input tx_request_b, output ready);
endinterface

`default_nettype wire

[rtl/tpsbb_ring_mem.sv]
// Byte ring memory of one bridge direction, one write and one registered read port.
// Depends on tpsbb_pkg.
`default_nettype none

module tpsbb_ring_mem import tpsbb_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire byte_t         wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output      byte_t         rdata_o
);

  byte_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/tpsbb_text_mem.sv]
// Text buffer memory of one port, one write and two registered read ports.
// The second read port fetches the successor of the current text position. Depends on tpsbb_pkg.
`default_nettype none

module tpsbb_text_mem import tpsbb_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire byte_t         wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr0_i,
  input  wire logic [AW-1:0] raddr1_i,
  output      byte_t         rdata0_o,
  output      byte_t         rdata1_o
);

  byte_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

`default_nettype wire

[rtl/two_port_serial_byte_bridge.sv]
// Two-port serial byte bridge: ring FIFOs between two ports plus per-port text buffers.
// Result path: an accepted transaction is registered together with its memory reads, then
// executed, and its result is registered at the output, where it waits while the output is stalled.
// A new transaction is taken only in the idle state, so each one is executed and written back
// before the next is accepted; a stalled output holds the execute step.
// Reset: pointers and flags clear at once; a clearing pass then writes zero to every text
// buffer address, during which no transaction is accepted.
`default_nettype none

module two_port_serial_byte_bridge import tpsbb_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 64,
  parameter int unsigned TEXT_DEPTH = 32
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  tpsbb_in_if.sink    in_i,
  tpsbb_out_if.source out_o
);

  localparam int unsigned FAW = $clog2(FIFO_DEPTH);
  localparam int unsigned TAW = $clog2(TEXT_DEPTH);
  localparam int unsigned IW  = (TAW > IDX_W) ? TAW : IDX_W;

  state_e state_q, state_d;
  logic [TAW-1:0] clr_q, clr_d;

  logic [1:0][FAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0][FAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [1:0][TAW-1:0] pos_q, pos_d;
  logic [1:0]          act_q, act_d;
  logic [1:0]          txr_q, txr_d;

  op_e              op_q;
  logic             port_q;
  byte_t            byte_q;
  logic [IDX_W-1:0] idx_q;

  logic  out_valid_q;
  logic  res_sent_q;
  byte_t res_byte_q;
  logic  res_drop_q;
  logic  res_txa_q;
  logic  res_txb_q;

  logic in_ready;
  logic accept;
  logic adv;
  logic clearing;

  logic [1:0] ring_we;
  byte_t      ring_rd [2];
  logic [1:0] text_we_ex;
  byte_t      text_rd0 [2];
  byte_t      text_rd1 [2];

  logic [TAW-1:0] pos_sel;
  logic [TAW-1:0] text_ra0;
  logic [TAW-1:0] text_ra1;
  logic [TAW-1:0] text_wa;
  byte_t          text_wd;
  logic [IW-1:0]  idx_ext;

  logic     dest;
  byte_t    t0;
  byte_t    t1;
  byte_t    fifo_byte;
  logic     last_pos;
  logic     end_text;
  logic [FAW-1:0] nx_ptr;
  logic     sent;
  byte_t    sbyte;
  logic     dropped;

  function automatic logic [FAW-1:0] ring_next(input logic [FAW-1:0] p);
    return (p == FAW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == TAW'(TEXT_DEPTH - 1)) begin
          state_d = ST_IDLE;
          clr_d   = '0;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready = 1'b0;
    adv      = 1'b0;
    clearing = 1'b0;
    case (state_q)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE:  in_ready = 1'b1;
      ST_EXEC:  adv      = !out_valid_q || out_o.ready;
      default:  clearing = 1'b0;
    endcase
  end

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  // Read addresses are formed from the incoming transaction.
  assign pos_sel  = pos_q[in_i.port];
  assign text_ra0 = (in_i.operation == OP_START_TEXT) ? '0 : pos_sel;
  assign text_ra1 = (pos_sel == TAW'(TEXT_DEPTH - 1)) ? '0 : pos_sel + 1'b1;

  assign idx_ext = IW'(idx_q);
  assign text_wa = clearing ? clr_q : idx_ext[TAW-1:0];
  assign text_wd = clearing ? '0 : byte_q;

  for (genvar g = 0; g < 2; g++) begin : g_port
    tpsbb_ring_mem #(
      .DEPTH (FIFO_DEPTH),
      .AW    (FAW)
    ) u_ring (
      .clk_i   (clk_i),
      .we_i    (ring_we[g] && adv),
      .waddr_i (wr_ptr_q[g]),
      .wdata_i (byte_q),
      .re_i    (accept),
      .raddr_i (rd_ptr_q[g]),
      .rdata_o (ring_rd[g])
    );

    tpsbb_text_mem #(
      .DEPTH (TEXT_DEPTH),
      .AW    (TAW)
    ) u_text (
      .clk_i    (clk_i),
      .we_i     (clearing || (text_we_ex[g] && adv)),
      .waddr_i  (text_wa),
      .wdata_i  (text_wd),
      .re_i     (accept),
      .raddr0_i (text_ra0),
      .raddr1_i (text_ra1),
      .rdata0_o (text_rd0[g]),
      .rdata1_o (text_rd1[g])
    );
  end

  // Execute step: reads have returned, compute the result and the write-back.
  always_comb begin
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    pos_d      = pos_q;
    act_d      = act_q;
    txr_d      = txr_q;
    ring_we    = 2'b00;
    text_we_ex = 2'b00;
    sent       = 1'b0;
    sbyte      = '0;
    dropped    = 1'b0;
    end_text   = 1'b0;
    dest       = ~port_q;
    t0         = text_rd0[port_q];
    t1         = text_rd1[port_q];
    fifo_byte  = ring_rd[port_q];
    last_pos   = (pos_q[port_q] == TAW'(TEXT_DEPTH - 1));
    nx_ptr     = ring_next(wr_ptr_q[dest]);
    case (op_q)
      OP_RX_BYTE: begin
        if (nx_ptr != rd_ptr_q[dest]) begin
          ring_we[dest]  = 1'b1;
          wr_ptr_d[dest] = nx_ptr;
        end else begin
          dropped = 1'b1;
        end
        txr_d[dest] = 1'b1;
      end
      OP_TX_READY: begin
        nx_ptr = ring_next(rd_ptr_q[port_q]);
        if (act_q[port_q]) begin
          if (t0 != '0) begin
            sent  = 1'b1;
            sbyte = t0;
            if (last_pos || t1 == '0) begin
              end_text = 1'b1;
            end else begin
              pos_d[port_q] = pos_q[port_q] + 1'b1;
            end
          end else begin
            end_text = 1'b1;
          end
          if (end_text) begin
            pos_d[port_q] = '0;
            act_d[port_q] = 1'b0;
            if (rd_ptr_q[port_q] == wr_ptr_q[port_q]) begin
              txr_d[port_q] = 1'b0;
            end
          end
        end else if (rd_ptr_q[port_q] != wr_ptr_q[port_q]) begin
          sent             = 1'b1;
          sbyte            = fifo_byte;
          rd_ptr_d[port_q] = nx_ptr;
          if (nx_ptr == wr_ptr_q[port_q]) begin
            txr_d[port_q] = 1'b0;
          end
        end else begin
          txr_d[port_q] = 1'b0;
        end
      end
      OP_LOAD_TEXT: begin
        if (32'(idx_q) < TEXT_DEPTH) begin
          text_we_ex[port_q] = 1'b1;
        end
      end
      OP_START_TEXT: begin
        if (t0 != '0) begin
          pos_d[port_q] = '0;
          act_d[port_q] = 1'b1;
          txr_d[port_q] = 1'b1;
        end
      end
      default: sent = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      pos_q       <= '0;
      act_q       <= '0;
      txr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (adv) begin
        wr_ptr_q    <= wr_ptr_d;
        rd_ptr_q    <= rd_ptr_d;
        pos_q       <= pos_d;
        act_q       <= act_d;
        txr_q       <= txr_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_i.operation;
      port_q <= in_i.port;
      byte_q <= in_i.data_byte;
      idx_q  <= in_i.text_index;
    end
    if (adv) begin
      res_sent_q <= sent;
      res_byte_q <= sbyte;
      res_drop_q <= dropped;
      res_txa_q  <= txr_d[0];
      res_txb_q  <= txr_d[1];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.sent_valid    = res_sent_q;
  assign out_o.sent_byte     = res_byte_q;
  assign out_o.queue_dropped = res_drop_q;
  assign out_o.tx_request_a  = res_txa_q;
  assign out_o.tx_request_b  = res_txb_q;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("accepted transaction did not enter the execute step");

  a_text_keeps_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q[0] |-> txr_q[0]) and (act_q[1] |-> txr_q[1]))
    else $error("text send active without a pending transmit request");

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !in_i.ready && !adv)
    else $error("transaction handled during the text clearing pass");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wr_ptr_q[0]) < FIFO_DEPTH && 32'(wr_ptr_q[1]) < FIFO_DEPTH &&
    32'(rd_ptr_q[0]) < FIFO_DEPTH && 32'(rd_ptr_q[1]) < FIFO_DEPTH)
    else $error("ring pointer beyond the ring depth");
`endif

endmodule

`default_nettype wire

[test/tb_two_port_serial_byte_bridge.sv]
`timescale 1ns / 1ps
// Self-checking testbench of two_port_serial_byte_bridge: directed events, then random bursts
// with random gaps and output stalls, checked against a cycle-free model of the bridge.
// Depends on tpsbb_pkg, tpsbb_in_if, tpsbb_out_if and the bridge RTL.

module tb_two_port_serial_byte_bridge import tpsbb_pkg::*; ();

  localparam int unsigned FIFO_DEPTH     = 64;
  localparam int unsigned TEXT_DEPTH     = 32;
  localparam int unsigned RANDOM_EVENTS  = 850;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct {
    op_e              op;
    logic             port;
    byte_t            data;
    logic [IDX_W-1:0] idx;
  } bridge_event_t;

  typedef struct {
    logic  sent_valid;
    byte_t sent_byte;
    logic  dropped;
    logic  req_a;
    logic  req_b;
  } bridge_result_t;

  typedef enum int {
    BURST_FILL,
    BURST_DRAIN,
    BURST_TEXT_FULL,
    BURST_TEXT,
    BURST_MIX
  } burst_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tpsbb_in_if  in_if ();
  tpsbb_out_if out_if ();

  two_port_serial_byte_bridge #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .TEXT_DEPTH(TEXT_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bridge state as the model sees it.
  byte_t       ring_mem [2][FIFO_DEPTH];
  int unsigned wr_ptr [2] = '{default: 0};
  int unsigned rd_ptr [2] = '{default: 0};
  byte_t       text_mem [2][TEXT_DEPTH] = '{default: '{default: 8'h00}};
  int unsigned text_pos [2] = '{default: 0};
  logic        text_on [2] = '{default: 1'b0};
  logic        tx_req [2] = '{default: 1'b0};

  bridge_event_t  pending_events[$];
  bridge_result_t expected_results[$];

  logic        in_offering = 1'b0;
  logic        hold_off;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned op_count [4] = '{default: 0};
  int unsigned bytes_sent = 0;
  int unsigned bytes_dropped = 0;
  int unsigned hold_count = 0;

  function automatic bridge_result_t bridge_predict(bridge_event_t ev);
    bridge_result_t res;
    int unsigned    p;
    int unsigned    dest;
    int unsigned    nxt;
    int unsigned    pos;
    byte_t          ch;
    res = '{sent_valid: 1'b0, sent_byte: 8'h00, dropped: 1'b0, req_a: 1'b0, req_b: 1'b0};
    p = ev.port;
    case (ev.op)
      OP_RX_BYTE: begin
        dest = p ^ 1;
        nxt = (wr_ptr[dest] + 1) % FIFO_DEPTH;
        if (nxt != rd_ptr[dest]) begin
          ring_mem[dest][wr_ptr[dest]] = ev.data;
          wr_ptr[dest] = nxt;
        end else begin
          res.dropped = 1'b1;
        end
        tx_req[dest] = 1'b1;
      end
      OP_TX_READY: begin
        if (text_on[p]) begin
          pos = text_pos[p];
          ch = (pos < TEXT_DEPTH) ? text_mem[p][pos] : 8'h00;
          if (ch != 8'h00) begin
            res.sent_valid = 1'b1;
            res.sent_byte = ch;
            pos++;
            if (pos >= TEXT_DEPTH || text_mem[p][pos] == 8'h00) begin
              text_pos[p] = 0;
              text_on[p] = 1'b0;
            end else begin
              text_pos[p] = pos;
            end
          end else begin
            text_pos[p] = 0;
            text_on[p] = 1'b0;
          end
          if (!text_on[p] && rd_ptr[p] == wr_ptr[p]) tx_req[p] = 1'b0;
        end else if (rd_ptr[p] != wr_ptr[p]) begin
          res.sent_valid = 1'b1;
          res.sent_byte = ring_mem[p][rd_ptr[p]];
          rd_ptr[p] = (rd_ptr[p] + 1) % FIFO_DEPTH;
          if (rd_ptr[p] == wr_ptr[p]) tx_req[p] = 1'b0;
        end else begin
          tx_req[p] = 1'b0;
        end
      end
      OP_LOAD_TEXT: begin
        if (ev.idx < TEXT_DEPTH) text_mem[p][ev.idx] = ev.data;
      end
      default: begin
        if (text_mem[p][0] != 8'h00) begin
          text_pos[p] = 0;
          text_on[p] = 1'b1;
          tx_req[p] = 1'b1;
        end
      end
    endcase
    res.req_a = tx_req[0];
    res.req_b = tx_req[1];
    return res;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_event(op_e op, logic port, byte_t data, logic [IDX_W-1:0] idx);
    bridge_event_t ev;
    ev.op = op;
    ev.port = port;
    ev.data = data;
    ev.idx = idx;
    pending_events.push_back(ev);
  endtask

  task automatic push_random();
    int unsigned r;
    op_e         op;
    byte_t       d;
    r = $urandom_range(0, 99);
    if (r < 35) op = OP_RX_BYTE;
    else if (r < 75) op = OP_TX_READY;
    else if (r < 90) op = OP_LOAD_TEXT;
    else op = OP_START_TEXT;
    d = 8'($urandom_range(0, 255));
    if (op == OP_LOAD_TEXT && $urandom_range(0, 4) == 0) d = 8'h00;
    push_event(op, 1'($urandom_range(0, 1)), d, IDX_W'($urandom_range(0, TEXT_DEPTH - 1)));
  endtask

  // Driver: offers queued events, with random gaps between transactions.
  always @(posedge clk_i or negedge rst_ni) begin
    bridge_event_t  cur;
    bridge_result_t res;
    int unsigned    gap_left;
    int unsigned    calm_left;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.operation <= OP_RX_BYTE;
      in_if.port <= 1'b0;
      in_if.data_byte <= 8'h00;
      in_if.text_index <= '0;
      in_offering = 1'b0;
      gap_left = 0;
      calm_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        res = bridge_predict(cur);
        expected_results.push_back(res);
        op_count[cur.op]++;
        if (res.sent_valid) bytes_sent++;
        if (res.dropped) bytes_dropped++;
        in_offering = 1'b0;
        if (hold_off || calm_left > 0) begin
          gap_left = 0;
          if (calm_left > 0) calm_left--;
        end else if ($urandom_range(0, 39) == 0) begin
          calm_left = $urandom_range(20, 60);
          gap_left = 0;
        end else begin
          gap_left = gap_len();
        end
      end
      if (!in_offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_events.size() > 0) begin
          cur = pending_events.pop_front();
          in_if.operation <= cur.op;
          in_if.port <= cur.port;
          in_if.data_byte <= cur.data;
          in_if.text_index <= cur.idx;
          in_offering = 1'b1;
        end
      end
      in_if.valid <= in_offering;
    end
  end

  // Monitor: random output stalls and the result check.
  always @(posedge clk_i or negedge rst_ni) begin
    bridge_result_t want;
    int unsigned    stall_left;
    int unsigned    calm_left;
    logic           rdy;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
      calm_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("Unexpected result: sent %0b byte %02h drop %0b req_a %0b req_b %0b",
                     out_if.sent_valid, out_if.sent_byte, out_if.queue_dropped,
                     out_if.tx_request_a, out_if.tx_request_b);
        end else begin
          want = expected_results.pop_front();
          if (out_if.sent_valid !== want.sent_valid || out_if.sent_byte !== want.sent_byte ||
              out_if.queue_dropped !== want.dropped || out_if.tx_request_a !== want.req_a ||
              out_if.tx_request_b !== want.req_b) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $write("Result %0d: expected sent %0b byte %02h drop %0b req_a %0b req_b %0b,",
                     results_seen, want.sent_valid, want.sent_byte, want.dropped,
                     want.req_a, want.req_b);
              $display(" got sent %0b byte %02h drop %0b req_a %0b req_b %0b",
                       out_if.sent_valid, out_if.sent_byte, out_if.queue_dropped,
                       out_if.tx_request_a, out_if.tx_request_b);
            end
          end
        end
        results_seen++;
      end
      if (hold_off) begin
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        rdy = 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        calm_left = $urandom_range(20, 80);
        rdy = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = gap_len();
        rdy = (stall_left == 0);
      end else begin
        rdy = 1'b1;
      end
      out_if.ready <= rdy;
    end
  end

  // Long output hold-offs so that the bridge fills up and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned seen_in;
    int unsigned hold_left;
    int unsigned next_hold;
    if (!rst_ni) begin
      hold_off <= 1'b0;
      seen_in = 0;
      hold_left = 0;
      next_hold = 300;
    end else begin
      if (in_if.valid && in_if.ready) seen_in++;
      if (hold_left > 0) begin
        hold_left--;
      end else if (seen_in >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold += 350;
        hold_count++;
      end
      hold_off <= (hold_left > 0);
    end
  end

  always @(posedge clk_i) begin
    int unsigned idle_cycles;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    burst_e      kind;
    int unsigned n_bursts;
    int unsigned directed_len;
    int unsigned p;
    int unsigned len;
    int unsigned r;
    in_if.valid = 1'b0;
    in_if.operation = OP_RX_BYTE;
    in_if.port = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.text_index = '0;
    out_if.ready = 1'b0;

    // Idle ports, empty text start, zero and all-ones bytes through the rings.
    push_event(OP_TX_READY, 1'b0, 8'hFF, 5'd31);
    push_event(OP_TX_READY, 1'b1, 8'h00, 5'd0);
    push_event(OP_START_TEXT, 1'b0, 8'h55, 5'd10);
    push_event(OP_RX_BYTE, 1'b0, 8'h00, 5'd0);
    push_event(OP_RX_BYTE, 1'b0, 8'hFF, 5'd31);
    push_event(OP_RX_BYTE, 1'b1, 8'hA5, 5'd21);
    push_event(OP_TX_READY, 1'b1, 8'h00, 5'd0);
    push_event(OP_TX_READY, 1'b1, 8'h00, 5'd0);
    push_event(OP_TX_READY, 1'b1, 8'h00, 5'd0);
    // Text sends ahead of queued bytes, restart while active, zero met mid-send.
    push_event(OP_LOAD_TEXT, 1'b0, 8'h48, 5'd0);
    push_event(OP_LOAD_TEXT, 1'b0, 8'h69, 5'd1);
    push_event(OP_LOAD_TEXT, 1'b0, 8'hFF, 5'd31);
    push_event(OP_LOAD_TEXT, 1'b1, 8'h7E, 5'd0);
    push_event(OP_START_TEXT, 1'b0, 8'h00, 5'd0);
    push_event(OP_TX_READY, 1'b0, 8'h00, 5'd0);
    push_event(OP_TX_READY, 1'b0, 8'h00, 5'd0);
    push_event(OP_TX_READY, 1'b0, 8'h00, 5'd0);
    push_event(OP_START_TEXT, 1'b1, 8'h00, 5'd0);
    push_event(OP_TX_READY, 1'b1, 8'h00, 5'd0);
    push_event(OP_START_TEXT, 1'b0, 8'h00, 5'd0);
    push_event(OP_TX_READY, 1'b0, 8'h00, 5'd0);
    push_event(OP_START_TEXT, 1'b0, 8'h00, 5'd0);
    push_event(OP_TX_READY, 1'b0, 8'h00, 5'd0);
    push_event(OP_RX_BYTE, 1'b1, 8'h3C, 5'd0);
    push_event(OP_LOAD_TEXT, 1'b0, 8'h00, 5'd1);
    push_event(OP_TX_READY, 1'b0, 8'h00, 5'd0);
    push_event(OP_TX_READY, 1'b0, 8'h00, 5'd0);
    directed_len = pending_events.size();

    n_bursts = 0;
    while (pending_events.size() < directed_len + RANDOM_EVENTS) begin
      if (n_bursts <= BURST_MIX) begin
        kind = burst_e'(n_bursts);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) kind = BURST_MIX;
        else if (r < 60) kind = BURST_FILL;
        else if (r < 75) kind = BURST_DRAIN;
        else if (r < 95) kind = BURST_TEXT;
        else kind = BURST_TEXT_FULL;
      end
      n_bursts++;
      p = $urandom_range(0, 1);
      case (kind)
        BURST_FILL: begin
          repeat (70) begin
            if ($urandom_range(0, 19) != 0)
              push_event(OP_RX_BYTE, 1'(p ^ 1), 8'($urandom_range(0, 255)),
                         IDX_W'($urandom_range(0, TEXT_DEPTH - 1)));
            else push_random();
          end
        end
        BURST_DRAIN: begin
          repeat (40) begin
            if ($urandom_range(0, 99) < 85)
              push_event(OP_TX_READY, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         IDX_W'($urandom_range(0, TEXT_DEPTH - 1)));
            else push_random();
          end
        end
        BURST_TEXT_FULL: begin
          for (int i = 0; i < TEXT_DEPTH; i++)
            push_event(OP_LOAD_TEXT, 1'(p), 8'($urandom_range(1, 255)), IDX_W'(i));
          push_event(OP_START_TEXT, 1'(p), 8'($urandom_range(0, 255)),
                     IDX_W'($urandom_range(0, 31)));
          repeat (TEXT_DEPTH + 2)
            push_event(OP_TX_READY, 1'(p), 8'($urandom_range(0, 255)),
                       IDX_W'($urandom_range(0, 31)));
        end
        BURST_TEXT: begin
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++)
            push_event(OP_LOAD_TEXT, 1'(p),
                       (i == 0 && $urandom_range(0, 9) == 0) ? 8'h00 :
                                                               8'($urandom_range(1, 255)),
                       IDX_W'(i));
          if ($urandom_range(0, 2) != 0) push_event(OP_LOAD_TEXT, 1'(p), 8'h00, IDX_W'(len));
          push_event(OP_START_TEXT, 1'(p), 8'($urandom_range(0, 255)),
                     IDX_W'($urandom_range(0, 31)));
          repeat (len + 3) begin
            if ($urandom_range(0, 4) != 0)
              push_event(OP_TX_READY, 1'(p), 8'($urandom_range(0, 255)),
                         IDX_W'($urandom_range(0, 31)));
            else push_random();
          end
        end
        default: begin
          repeat (30) push_random();
        end
      endcase
    end

    wait (rst_ni);
    while (pending_events.size() != 0 || in_offering || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      mismatch_count += expected_results.size();
    end

    $write("Covered %0d transactions: %0d received bytes (%0d dropped), ",
           results_seen, op_count[OP_RX_BYTE], bytes_dropped);
    $display("%0d ready events (%0d bytes sent), %0d text loads, %0d text starts.",
             op_count[OP_TX_READY], bytes_sent, op_count[OP_LOAD_TEXT],
             op_count[OP_START_TEXT]);
    $display("Output held off %0d times for %0d cycles; %0d mismatches.",
             hold_count, HOLD_CYCLES, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

endmodule
